>>> rtl/core/hmsct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hmsct_pkg
// Shared types and constants of the hours/minutes/seconds countdown relay timer.
// ----------------------------------------------------------------------------
package hmsct_pkg;

  // largest value a preset field can be set to
  localparam int unsigned FIELD_MAX      = 99;
  localparam int unsigned FIELD_W        = 7;
  localparam int unsigned TPS_W          = 16;
  localparam logic [15:0] TPS_RESET      = 16'd10000;
  localparam logic [6:0]  SIXTY_LESS_ONE = 7'd59;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 32;

  typedef enum logic [2:0] {
    MODE_BANNER = 3'd0,
    MODE_SET_S  = 3'd1,
    MODE_SET_M  = 3'd2,
    MODE_SET_H  = 3'd3,
    MODE_COUNT  = 3'd4,
    MODE_WAIT   = 3'd5
  } mode_e;

  // one field of the preset or running count
  typedef logic [FIELD_W-1:0] field_t;

  // adjust a preset: increment held at FIELD_MAX, then decrement held at zero
  function automatic field_t adjust_field(input field_t v, input logic up, input logic down);
    field_t r;
    r = v;
    if (up) begin
      if (r < field_t'(FIELD_MAX)) begin
        r = r + field_t'(1);
      end else begin
        r = field_t'(FIELD_MAX);
      end
    end
    if (down && (r != '0)) begin
      r = r - field_t'(1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/hms_countdown_relay_timer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hms_countdown_relay_timer
// Button-driven hours/minutes/seconds countdown timer driving a relay.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one transaction per cycle of button events and a base tick:
//   tdata[0] base_tick, [1] inc, [2] dec, [3] next, [4] start, [7:5] zero.
//   m_axis returns exactly one status transaction per input transaction:
//   mode, relay drive, expiry pulse and the shown hours, minutes, seconds.
//   cfg_we_i/cfg_wdata_i write ticks_per_second (reset 10000); write it only
//   while no transaction is in flight.
// Flow:
//   a transaction is taken into an input register, processed in one pass of
//   logic into the output register and shown on m_axis from that register.
//   One transaction per cycle is sustained while m_axis_tready is high; the
//   single-pass update of the mode, presets, count and prescaler sets that figure.
// Reset:
//   rst_ni clears both stages, returns to banner mode with zero presets,
//   zero count, prescaler cleared and relay off.
// Stalls:
//   when m_axis_tready is low the result holds; the input register still
//   takes one more transaction, then s_axis_tready drops until space frees.
// ----------------------------------------------------------------------------
module hms_countdown_relay_timer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config: ticks_per_second
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // base_tick, inc_pressed, dec_pressed, next_pressed, start_pressed, 3 zero bits
  input  wire logic [hmsct_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // mode[2:0], relay_on, expired, shown_hours[6:0], shown_minutes[6:0],
  // shown_seconds[6:0], 6 zero bits
  output logic [hmsct_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic                    in_valid_q;
  logic [4:0]              in_data_q;
  logic                    out_valid_q;
  logic [hmsct_pkg::OUT_TDATA_W-1:0] out_data_q, out_data_d;
  logic                    out_free;
  logic                    fire;

  logic [hmsct_pkg::TPS_W-1:0] tps_q;
  logic [hmsct_pkg::TPS_W-1:0] presc_q, presc_d;
  hmsct_pkg::mode_e        mode_q, mode_d;
  hmsct_pkg::field_t       pre_s_q, pre_m_q, pre_h_q;
  hmsct_pkg::field_t       pre_s_d, pre_m_d, pre_h_d;
  hmsct_pkg::field_t       cnt_s_q, cnt_m_q, cnt_h_q;
  hmsct_pkg::field_t       cnt_s_d, cnt_m_d, cnt_h_d;
  logic                    relay_q, relay_d;
  logic                    expired;
  logic [hmsct_pkg::TPS_W:0] presc_inc;

  logic tick, inc, dec, nxt, start;

  assign tick  = in_data_q[0];
  assign inc   = in_data_q[1];
  assign dec   = in_data_q[2];
  assign nxt   = in_data_q[3];
  assign start = in_data_q[4];

  assign out_free      = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || fire;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign presc_inc     = {1'b0, presc_q} + 17'd1;

  always_comb begin
    mode_d  = mode_q;
    pre_s_d = pre_s_q;
    pre_m_d = pre_m_q;
    pre_h_d = pre_h_q;
    cnt_s_d = cnt_s_q;
    cnt_m_d = cnt_m_q;
    cnt_h_d = cnt_h_q;
    presc_d = presc_q;
    relay_d = relay_q;
    expired = 1'b0;

    unique case (mode_q) inside
      hmsct_pkg::MODE_BANNER: begin
        relay_d = 1'b0;
        mode_d  = hmsct_pkg::MODE_SET_S;
      end
      hmsct_pkg::MODE_SET_S, hmsct_pkg::MODE_SET_M, hmsct_pkg::MODE_SET_H: begin
        if (mode_q == hmsct_pkg::MODE_SET_S) begin
          pre_s_d = hmsct_pkg::adjust_field(pre_s_q, inc, dec);
        end else if (mode_q == hmsct_pkg::MODE_SET_M) begin
          pre_m_d = hmsct_pkg::adjust_field(pre_m_q, inc, dec);
        end else begin
          pre_h_d = hmsct_pkg::adjust_field(pre_h_q, inc, dec);
        end
        if (nxt) begin
          unique case (mode_q)
            hmsct_pkg::MODE_SET_S: mode_d = hmsct_pkg::MODE_SET_M;
            hmsct_pkg::MODE_SET_M: mode_d = hmsct_pkg::MODE_SET_H;
            default:               mode_d = hmsct_pkg::MODE_SET_S;
          endcase
        end else if (start) begin
          cnt_s_d = pre_s_d;
          cnt_m_d = pre_m_d;
          cnt_h_d = pre_h_d;
          presc_d = '0;
          mode_d  = hmsct_pkg::MODE_COUNT;
        end
      end
      hmsct_pkg::MODE_COUNT: begin
        if (tick) begin
          // a zero setting compares as one: every tick is a second
          if (presc_inc >= {1'b0, tps_q}) begin
            presc_d = '0;
            if (cnt_s_q != '0) begin
              cnt_s_d = cnt_s_q - 7'd1;
            end else if (cnt_m_q != '0) begin
              cnt_s_d = hmsct_pkg::SIXTY_LESS_ONE;
              cnt_m_d = cnt_m_q - 7'd1;
            end else if (cnt_h_q != '0) begin
              cnt_s_d = hmsct_pkg::SIXTY_LESS_ONE;
              cnt_m_d = hmsct_pkg::SIXTY_LESS_ONE;
              cnt_h_d = cnt_h_q - 7'd1;
            end
          end else begin
            presc_d = presc_inc[hmsct_pkg::TPS_W-1:0];
          end
        end
        if ((cnt_s_d == '0) && (cnt_m_d == '0) && (cnt_h_d == '0)) begin
          relay_d = 1'b1;
          expired = 1'b1;
          mode_d  = hmsct_pkg::MODE_WAIT;
        end
      end
      hmsct_pkg::MODE_WAIT: begin
        if (dec) begin
          mode_d = hmsct_pkg::MODE_BANNER;
        end
      end
      default: begin
        mode_d = hmsct_pkg::MODE_BANNER;
      end
    endcase

    out_data_d        = '0;
    out_data_d[2:0]   = mode_d;
    out_data_d[3]     = relay_d;
    out_data_d[4]     = expired;
    if ((mode_d == hmsct_pkg::MODE_COUNT) || (mode_d == hmsct_pkg::MODE_WAIT)) begin
      out_data_d[11:5]  = cnt_h_d;
      out_data_d[18:12] = cnt_m_d;
      out_data_d[25:19] = cnt_s_d;
    end else begin
      out_data_d[11:5]  = pre_h_d;
      out_data_d[18:12] = pre_m_d;
      out_data_d[25:19] = pre_s_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      tps_q       <= hmsct_pkg::TPS_RESET;
      mode_q      <= hmsct_pkg::MODE_BANNER;
      pre_s_q     <= '0;
      pre_m_q     <= '0;
      pre_h_q     <= '0;
      cnt_s_q     <= '0;
      cnt_m_q     <= '0;
      cnt_h_q     <= '0;
      presc_q     <= '0;
      relay_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tps_q <= cfg_wdata_i;
      end
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (fire) begin
        mode_q  <= mode_d;
        pre_s_q <= pre_s_d;
        pre_m_q <= pre_m_d;
        pre_h_q <= pre_h_d;
        cnt_s_q <= cnt_s_d;
        cnt_m_q <= cnt_m_d;
        cnt_h_q <= cnt_h_d;
        presc_q <= presc_d;
        relay_q <= relay_d;
      end
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata[4:0];
    end
    if (fire) begin
      out_data_q <= out_data_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (mode_q == hmsct_pkg::MODE_BANNER)
    |=> (mode_q == hmsct_pkg::MODE_SET_S) && !relay_q)
    else $error("banner did not clear relay and enter set seconds");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == hmsct_pkg::MODE_SET_S) || (mode_q == hmsct_pkg::MODE_SET_M) ||
    (mode_q == hmsct_pkg::MODE_SET_H) || (mode_q == hmsct_pkg::MODE_COUNT)
    |-> !relay_q)
    else $error("relay on outside wait mode");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (mode_q == hmsct_pkg::MODE_COUNT) && expired
    |=> (mode_q == hmsct_pkg::MODE_WAIT) && relay_q &&
        (cnt_s_q == '0) && (cnt_m_q == '0) && (cnt_h_q == '0))
    else $error("expiry did not leave a zero count in wait mode");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q[4]
    |-> (out_data_q[2:0] == hmsct_pkg::MODE_WAIT) && out_data_q[3])
    else $error("expired result without wait mode and relay");

endmodule
`default_nettype wire
